// File: rtl/core/sbdm_pkg.sv
// Shared constants and types for the sort-based duplicate marker.
`timescale 1ns / 1ps
`default_nettype none
package sbdm_pkg;

    // Fixed port widths of the item and result fields
    localparam int KEY_IN_W  = 64;
    localparam int IDX_OUT_W = 6;

    // Sequencer state codes
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the broadcast key in sorted position
        logic shift;    // move every entry one cell toward the head
    } t_cell_ctrl;

endpackage
`default_nettype wire

// File: rtl/core/sbdm_cell.sv
// One cell of the insertion-sort chain: holds one key and its arrival index.
`timescale 1ns / 1ps
`default_nettype none
module sbdm_cell #(
    parameter int KEY_W = 64,
    parameter int IDX_W = 6
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire sbdm_pkg::t_cell_ctrl i_ctrl,
    input  wire  [KEY_W-1:0]         i_new_key,
    input  wire  [IDX_W-1:0]         i_new_idx,
    // neighbor toward the head (used while inserting)
    input  wire                      i_left_less,
    input  wire                      i_left_valid,
    input  wire  [KEY_W-1:0]         i_left_key,
    input  wire  [IDX_W-1:0]         i_left_idx,
    // neighbor toward the tail (used while draining)
    input  wire                      i_right_valid,
    input  wire  [KEY_W-1:0]         i_right_key,
    input  wire  [IDX_W-1:0]         i_right_idx,
    output logic                     o_less,
    output logic                     o_valid,
    output logic [KEY_W-1:0]         o_key,
    output logic [IDX_W-1:0]         o_idx
);
    import sbdm_pkg::*;

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key,   n_key;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic             less;

    // New key sorts ahead of this entry; empty cells act as +infinity.
    // Equal keys keep the earlier arrival first.
    assign less = !r_valid || (i_new_key < r_key);

    // Displaced entries move one cell toward the tail; an empty left
    // neighbor hands on its empty slot, so only the first free cell fills.
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_idx   = r_idx;
        if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_idx   = i_right_idx;
        end else if (i_ctrl.insert && less) begin
            if (i_left_less) begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_idx   = i_left_idx;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_idx   = i_new_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_idx <= n_idx;
    end

    assign o_less  = less;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_idx   = r_idx;

endmodule
`default_nettype wire

// File: rtl/core/sort_based_duplicate_marker_top.sv
// Top level: load sequencer, sorting cell chain, drain and duplicate flagging.
//
//  Channel   Direction  Handshake              Beat fields
//  item      in         start & !busy          i_bucket_key, i_last_item
//  result    out        o_result_valid strobe  o_item_index, o_item_key,
//                                              o_dup_this_pass, o_dup_before,
//                                              o_pass_overflow, o_last_result
//
//  Loading takes one item per cycle; each key is placed in sorted position in
//  the cell chain in the cycle it arrives. After the last item, busy stays high
//  while the chain shifts one result out per cycle, once for each item held (at
//  most MAX_ITEMS); each result is registered and appears in the cycle after its shift.
//  Synchronous reset empties the chain and clears all sticky duplicate flags.
//  The receiver cannot stall; the strobe lasts one cycle per result.
`timescale 1ns / 1ps
`default_nettype none
module sort_based_duplicate_marker_top #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [sbdm_pkg::KEY_IN_W-1:0]    i_bucket_key,
    input  wire                              i_last_item,
    output logic                             o_result_valid,
    output logic [sbdm_pkg::IDX_OUT_W-1:0]   o_item_index,
    output logic [sbdm_pkg::KEY_IN_W-1:0]    o_item_key,
    output logic                             o_dup_this_pass,
    output logic                             o_dup_before,
    output logic                             o_pass_overflow,
    output logic                             o_last_result
);
    import sbdm_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic                 r_state, n_state;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;
    logic                 r_ovf,   n_ovf;
    logic                 r_first;
    logic [KEY_BITS-1:0]  r_prev_key;
    logic [MAX_ITEMS-1:0] r_sticky;

    logic                 accept, full, emit, dup_now;
    logic [KEY_BITS-1:0]  new_key;
    t_cell_ctrl           ctrl;

    logic                 c_less  [MAX_ITEMS];
    logic                 c_valid [MAX_ITEMS];
    logic [KEY_BITS-1:0]  c_key   [MAX_ITEMS];
    logic [IDX_W-1:0]     c_idx   [MAX_ITEMS];

    // Input handshake and chain commands
    assign busy        = (r_state == ST_DRAIN);
    assign accept      = start && !busy;
    assign full        = (r_cnt == CNT_MAX);
    assign new_key     = i_bucket_key[KEY_BITS-1:0];
    assign emit        = (r_state == ST_DRAIN);
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = emit;

    // Sequencer: count arrivals while loading, count down results while draining
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CNT_ONE;
                    end
                    if (i_last_item) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            // overflow flag lives until the pass has drained
            r_ovf   <= (emit && r_cnt == CNT_ONE) ? 1'b0 : n_ovf;
        end
    end

    // Sorting chain: head cell holds the smallest key
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                left_less;
        logic                left_valid;
        logic [KEY_BITS-1:0] left_key;
        logic [IDX_W-1:0]    left_idx;
        logic                right_valid;
        logic [KEY_BITS-1:0] right_key;
        logic [IDX_W-1:0]    right_idx;

        if (g == 0) begin : g_head
            assign left_less  = 1'b0;
            assign left_valid = 1'b0;
            assign left_key   = new_key;
            assign left_idx   = r_cnt[IDX_W-1:0];
        end else begin : g_mid
            assign left_less  = c_less[g-1];
            assign left_valid = c_valid[g-1];
            assign left_key   = c_key[g-1];
            assign left_idx   = c_idx[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = c_key[g];
            assign right_idx   = c_idx[g];
        end else begin : g_body
            assign right_valid = c_valid[g+1];
            assign right_key   = c_key[g+1];
            assign right_idx   = c_idx[g+1];
        end

        sbdm_cell #(
            .KEY_W (KEY_BITS),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_new_key     (new_key),
            .i_new_idx     (r_cnt[IDX_W-1:0]),
            .i_left_less   (left_less),
            .i_left_valid  (left_valid),
            .i_left_key    (left_key),
            .i_left_idx    (left_idx),
            .i_right_valid (right_valid),
            .i_right_key   (right_key),
            .i_right_idx   (right_idx),
            .o_less        (c_less[g]),
            .o_valid       (c_valid[g]),
            .o_key         (c_key[g]),
            .o_idx         (c_idx[g])
        );
    end

    // Duplicate within the pass: head key equals the previous result's key
    assign dup_now = !r_first && (c_key[0] == r_prev_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 1'b1;
            r_sticky <= '0;
        end else begin
            if (emit) begin
                r_first <= (r_cnt == CNT_ONE);
                if (dup_now) begin
                    r_sticky[c_idx[0]] <= 1'b1;
                end
            end
        end
        if (emit) begin
            r_prev_key <= c_key[0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= emit;
        end
        if (emit) begin
            o_item_index    <= IDX_OUT_W'(c_idx[0]);
            o_item_key      <= KEY_IN_W'(c_key[0]);
            o_dup_this_pass <= dup_now;
            o_dup_before    <= r_sticky[c_idx[0]];
            o_pass_overflow <= r_ovf;
            o_last_result   <= (r_cnt == CNT_ONE);
        end
    end

    // Checks
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> c_valid[0])
        else $error("drain reads an empty head cell");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("item count beyond capacity");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(emit))
        else $error("result strobe without a drain cycle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result) |-> !busy && r_cnt == '0)
        else $error("last result while items remain");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for the sort-based duplicate marker: directed and random passes checked per beat.
`timescale 1ns / 1ps
module tb_top;

    import sbdm_pkg::*;

    localparam int MAX_ITEMS  = 64;
    localparam int KEY_BITS   = 64;
    localparam logic [KEY_IN_W-1:0] KEY_MASK =
        (KEY_BITS >= 64) ? {KEY_IN_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

    // One sorted result beat
    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [KEY_IN_W-1:0]  key;
        logic                 dup_now;
        logic                 dup_prior;
        logic                 ovf;
        logic                 tail;
    } t_sorted_beat;

    // Directed stimulus row; typed rows are single-item passes with a known result
    typedef struct packed {
        logic [KEY_IN_W-1:0] key;
        logic                last;
        logic                typed;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [KEY_IN_W-1:0]   i_bucket_key;
    logic                  i_last_item;
    logic                  o_result_valid;
    logic [IDX_OUT_W-1:0]  o_item_index;
    logic [KEY_IN_W-1:0]   o_item_key;
    logic                  o_dup_this_pass;
    logic                  o_dup_before;
    logic                  o_pass_overflow;
    logic                  o_last_result;

    // Shadow state of the block
    logic [KEY_IN_W-1:0]   arrival_key [MAX_ITEMS];
    bit                    ever_dup [MAX_ITEMS];
    int                    held_count;
    bit                    dropped;

    t_sorted_beat          sorted_due [$];
    int                    mismatch_count;
    int                    idle_pct;

    sort_based_duplicate_marker_top #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_bucket_key    (i_bucket_key),
        .i_last_item     (i_last_item),
        .o_result_valid  (o_result_valid),
        .o_item_index    (o_item_index),
        .o_item_key      (o_item_key),
        .o_dup_this_pass (o_dup_this_pass),
        .o_dup_before    (o_dup_before),
        .o_pass_overflow (o_pass_overflow),
        .o_last_result   (o_last_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 100)
            $display("tb_top: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Store one key; on the closing item, sort the pass and produce its beats
    task automatic sort_and_flag(input logic [KEY_IN_W-1:0] key_in, input logic last_in,
                                 output t_sorted_beat beats[$]);
        logic [KEY_IN_W-1:0] key;
        int                  order [MAX_ITEMS];
        bit                  now_dup [MAX_ITEMS];
        int                  cnt, i, j, cur;
        t_sorted_beat        b;
        beats = {};
        key = key_in & KEY_MASK;
        if (held_count < MAX_ITEMS) begin
            arrival_key[held_count] = key;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!last_in)
            return;
        cnt = held_count;
        for (i = 0; i < cnt; i++)
            order[i] = i;
        // stable insertion sort keeps equal keys in ascending index order
        for (i = 1; i < cnt; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && arrival_key[cur] < arrival_key[order[j-1]]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (i = 0; i < cnt; i++) begin
            b.idx       = IDX_OUT_W'(order[i]);
            b.key       = arrival_key[order[i]];
            b.dup_now   = (i > 0) && (arrival_key[order[i-1]] == arrival_key[order[i]]);
            b.dup_prior = ever_dup[order[i]];
            b.ovf       = dropped;
            b.tail      = (i == cnt - 1);
            now_dup[i]  = b.dup_now;
            beats       = {beats, b};
        end
        // sticky flags change only after the whole pass has reported
        for (i = 0; i < cnt; i++)
            if (now_dup[i])
                ever_dup[order[i]] = 1'b1;
        held_count = 0;
        dropped    = 1'b0;
    endtask

    // Drive one item and hold it until the block takes it
    task automatic put_item(input logic [KEY_IN_W-1:0] key, input logic last, input bit typed);
        t_sorted_beat beats [$];
        t_sorted_beat b;
        @(negedge i_clk);
        start        <= 1'b1;
        i_bucket_key <= key;
        i_last_item  <= last;
        do @(posedge i_clk); while (busy);
        sort_and_flag(key, last, beats);
        if (typed) begin
            // lone item of a pass: index 0, never a duplicate, no overflow
            b = '{idx: '0, key: key & KEY_MASK, dup_now: 1'b0, dup_prior: 1'b0,
                  ovf: 1'b0, tail: 1'b1};
            sorted_due = {sorted_due, b};
        end else begin
            foreach (beats[k])
                sorted_due = {sorted_due, beats[k]};
        end
    endtask

    // Random sender gap with junk on the data ports
    task automatic maybe_idle();
        int n;
        if ($urandom_range(0, 99) < idle_pct) begin
            n = $urandom_range(1, 5);
            @(negedge i_clk);
            start        <= 1'b0;
            i_bucket_key <= {$urandom, $urandom};
            i_last_item  <= 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [KEY_IN_W-1:0] pool_key();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return {1'b1, 31'($urandom), 32'($urandom)};
            3: return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Result checker: strobe sampled at the rising edge
    always @(posedge i_clk) begin
        t_sorted_beat exp_b;
        if (i_rst_n && o_result_valid) begin
            if (sorted_due.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                exp_b = sorted_due.pop_front();
                if (o_item_index !== exp_b.idx)
                    flag_mismatch($sformatf("item_index %0d, expected %0d",
                                            o_item_index, exp_b.idx));
                if (o_item_key !== exp_b.key)
                    flag_mismatch($sformatf("item_key %h, expected %h", o_item_key, exp_b.key));
                if (o_dup_this_pass !== exp_b.dup_now)
                    flag_mismatch($sformatf("dup_this_pass %b, expected %b (index %0d)",
                                            o_dup_this_pass, exp_b.dup_now, exp_b.idx));
                if (o_dup_before !== exp_b.dup_prior)
                    flag_mismatch($sformatf("dup_before %b, expected %b (index %0d)",
                                            o_dup_before, exp_b.dup_prior, exp_b.idx));
                if (o_pass_overflow !== exp_b.ovf)
                    flag_mismatch($sformatf("pass_overflow %b, expected %b",
                                            o_pass_overflow, exp_b.ovf));
                if (o_last_result !== exp_b.tail)
                    flag_mismatch($sformatf("last_result %b, expected %b",
                                            o_last_result, exp_b.tail));
            end
        end
    end

    // Directed table: lone extremes, unsigned order, ties, sticky reuse of indexes
    t_stim_row dir_rows [20] = '{
        '{64'h0000_0000_0000_0000, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b1},
        '{64'h0000_0000_0000_0001, 1'b1, 1'b1},
        '{64'h8000_0000_0000_0000, 1'b0, 1'b0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{64'h8000_0000_0000_0000, 1'b0, 1'b0},
        '{64'h0000_0000_0000_0000, 1'b0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0},
        '{64'h0000_0000_0000_0005, 1'b0, 1'b0},
        '{64'h0000_0000_0000_0004, 1'b0, 1'b0},
        '{64'h0000_0000_0000_0003, 1'b0, 1'b0},
        '{64'h0000_0000_0000_0002, 1'b0, 1'b0},
        '{64'h0000_0000_0000_0001, 1'b1, 1'b0},
        '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b1}
    };

    initial begin
        int                  phase, sent, len, first_pass, i;
        int                  pct [3];
        int                  quota [3];
        logic [KEY_IN_W-1:0] pool [3];
        logic [KEY_IN_W-1:0] key;
        pct   = '{19, 76, 0};
        quota = '{20, 20, 40};
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_bucket_key   = '0;
        i_last_item    = 1'b0;
        mismatch_count = 0;
        held_count     = 0;
        dropped        = 1'b0;
        foreach (ever_dup[k])
            ever_dup[k] = 1'b0;
        idle_pct = pct[0];
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            put_item(dir_rows[r].key, dir_rows[r].last, dir_rows[r].typed);
            maybe_idle();
        end

        // Random passes: short with colliding keys, one filling and overflowing the store
        for (phase = 0; phase < 3; phase++) begin
            idle_pct   = pct[phase];
            sent       = 0;
            first_pass = 1;
            while (sent < quota[phase]) begin
                if (first_pass && phase == 1)
                    len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
                else
                    len = $urandom_range(1, 8);
                first_pass = 0;
                for (i = 0; i < 3; i++)
                    pool[i] = pool_key();
                for (i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        5, 6, 7: key = {$urandom, $urandom};
                        8:       key = $urandom_range(0, 1) ? '1 : '0;
                        9:       key = pool[0] ^ 64'h8000_0000_0000_0000;
                        default: key = pool[$urandom_range(0, 2)];
                    endcase
                    put_item(key, i == len - 1, 1'b0);
                    maybe_idle();
                end
                sent += len;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (MAX_ITEMS + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sort_based_duplicate_marker_top.f
rtl/core/sbdm_pkg.sv
rtl/core/sbdm_cell.sv
rtl/core/sort_based_duplicate_marker_top.sv
bench/tb_top.sv
